FILE: sv/otsu_threshold_binarizer_assert.svh
// assertion macros for the otsu binarizer checker
`ifndef OTSU_THRESHOLD_BINARIZER_ASSERT_SVH
`define OTSU_THRESHOLD_BINARIZER_ASSERT_SVH

// same-cycle implication
`define OTB_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/otb_pkg.sv
package otb_pkg;

    localparam int NUM_BINS   = 256;
    localparam int BIN_W      = 8;
    localparam int MAX_PIXELS = 65536;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = CNT_W + BIN_W;
    localparam int SCORE_W    = 2 * CNT_W + 2 * BIN_W;

    localparam logic [BIN_W-1:0] FG_VALUE = 8'hFF;
    localparam logic [BIN_W-1:0] BG_VALUE = 8'h00;

    localparam logic KIND_ACCUM    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [BIN_W-1:0] pixel;
        logic             last;
    } otb_in_t;

    typedef struct packed {
        logic [BIN_W-1:0] mask_value;
        logic [BIN_W-1:0] threshold;
        logic             threshold_done;
    } otb_out_t;

    typedef struct packed {
        logic             rd_en;
        logic [BIN_W-1:0] rd_addr;
        logic             clr_en;
        logic [BIN_W-1:0] clr_addr;
    } hist_req_t;

endpackage

FILE: sv/otb_hist.sv
module otb_hist (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        acc_valid,
    input  logic [otb_pkg::BIN_W-1:0]   acc_bin,
    input  otb_pkg::hist_req_t          req,
    output logic [otb_pkg::CNT_W-1:0]   rd_data
);

    logic [otb_pkg::CNT_W-1:0] mem [otb_pkg::NUM_BINS];

    logic [otb_pkg::CNT_W-1:0] rd_data_reg;
    logic                      p1_valid_reg;
    logic [otb_pkg::BIN_W-1:0] p1_bin_reg;
    logic                      lw_valid_reg;
    logic [otb_pkg::BIN_W-1:0] lw_bin_reg;
    logic [otb_pkg::CNT_W-1:0] lw_data_reg;

    logic                      rd_en;
    logic [otb_pkg::BIN_W-1:0] rd_addr;
    logic                      wr_en;
    logic [otb_pkg::BIN_W-1:0] wr_addr;
    logic [otb_pkg::CNT_W-1:0] wr_data;
    logic [otb_pkg::CNT_W-1:0] base;

    // forward the previous write when the same bin follows directly
    always_comb begin
        base    = (lw_valid_reg && lw_bin_reg == p1_bin_reg) ? lw_data_reg : rd_data_reg;
        rd_en   = req.rd_en || acc_valid;
        rd_addr = req.rd_en ? req.rd_addr : acc_bin;
        wr_en   = p1_valid_reg || req.clr_en;
        wr_addr = p1_valid_reg ? p1_bin_reg : req.clr_addr;
        wr_data = p1_valid_reg ? base + 1'b1 : '0;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= acc_valid;
            lw_valid_reg <= p1_valid_reg;
        end
        p1_bin_reg  <= acc_bin;
        lw_bin_reg  <= p1_bin_reg;
        lw_data_reg <= wr_data;
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/otb_div.sv
module otb_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [otb_pkg::SUM_W-1:0]   dividend,
    input  logic [otb_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [otb_pkg::BIN_W-1:0]   quotient
);

    logic [otb_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [otb_pkg::SUM_W-1:0] dsh_reg, dsh_next;
    logic [otb_pkg::BIN_W-1:0] q_reg, q_next;
    logic [2:0]                i_reg, i_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic                      ge;

    // quotient is known to fit in one grey level, so one bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ge        = rem_reg >= dsh_reg;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = {1'b0, divisor, {(otb_pkg::BIN_W-1){1'b0}}};
            i_next    = 3'd7;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[otb_pkg::BIN_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (i_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                i_next = i_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        i_reg   <= i_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: sv/otb_search.sv
module otb_search (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [otb_pkg::CNT_W-1:0]   total,
    input  logic [otb_pkg::CNT_W-1:0]   rd_data,
    output otb_pkg::hist_req_t          req,
    output logic                        done,
    output logic [otb_pkg::BIN_W-1:0]   thr
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_WB   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIV1 = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_MUL1 = 4'd7;
    localparam logic [3:0] S_MUL2 = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_CLR  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    localparam int CW = otb_pkg::CNT_W;
    localparam int SW = otb_pkg::SUM_W;
    localparam int BW = otb_pkg::BIN_W;
    localparam int PW = 2 * otb_pkg::CNT_W;
    localparam int XW = otb_pkg::SCORE_W;

    logic [3:0]    st_reg, st_next;
    logic [BW:0]   a_reg, a_next;
    logic          dv_reg, dv_next;
    logic [BW-1:0] di_reg, di_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [BW-1:0] t_reg, t_next;
    logic [CW-1:0] wb_reg, wb_next;
    logic [CW-1:0] wf_reg, wf_next;
    logic [SW-1:0] sumb_reg, sumb_next;
    logic [SW-1:0] sumf_reg, sumf_next;
    logic [BW-1:0] mb_reg, mb_next;
    logic [BW-1:0] mf_reg, mf_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [2*BW-1:0] d2_reg, d2_next;
    logic [XW-1:0] score_reg, score_next;
    logic [XW-1:0] best_reg, best_next;
    logic [BW-1:0] thr_reg, thr_next;

    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic [CW-1:0] div_divisor;
    logic          div_done;
    logic [BW-1:0] div_q;
    logic [BW-1:0] diff;
    logic          at_end;

    otb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        st_next    = st_reg;
        a_next     = a_reg;
        dv_next    = 1'b0;
        di_next    = a_reg[BW-1:0];
        sum_next   = sum_reg;
        t_next     = t_reg;
        wb_next    = wb_reg;
        wf_next    = wf_reg;
        sumb_next  = sumb_reg;
        sumf_next  = sumf_reg;
        mb_next    = mb_reg;
        mf_next    = mf_reg;
        prod_next  = prod_reg;
        d2_next    = d2_reg;
        score_next = score_reg;
        best_next  = best_reg;
        thr_next   = thr_reg;
        req        = '0;
        div_start  = 1'b0;
        div_dividend = sumb_reg;
        div_divisor  = wb_reg;
        diff       = (mb_reg > mf_reg) ? mb_reg - mf_reg : mf_reg - mb_reg;
        at_end     = t_reg == BW'(otb_pkg::NUM_BINS - 1);
        done       = 1'b0;

        unique case (st_reg)
            S_IDLE: begin
                if (start) begin
                    a_next   = '0;
                    sum_next = '0;
                    st_next  = S_SUM;
                end
            end
            // total intensity, one bin per cycle
            S_SUM: begin
                req.rd_en   = !a_reg[BW];
                req.rd_addr = a_reg[BW-1:0];
                dv_next     = !a_reg[BW];
                if (!a_reg[BW]) begin
                    a_next = a_reg + 1'b1;
                end
                if (dv_reg) begin
                    sum_next = sum_reg + {{CW{1'b0}}, di_reg} * {{BW{1'b0}}, rd_data};
                end
                if (a_reg[BW] && !dv_reg) begin
                    t_next    = '0;
                    wb_next   = '0;
                    sumb_next = '0;
                    best_next = '0;
                    thr_next  = '0;
                    st_next   = S_RD;
                end
            end
            S_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = t_reg;
                st_next     = S_WB;
            end
            S_WB: begin
                wb_next   = wb_reg + rd_data;
                sumb_next = sumb_reg + {{CW{1'b0}}, t_reg} * {{BW{1'b0}}, rd_data};
                st_next   = S_CHK;
            end
            S_CHK: begin
                if (wb_reg == '0) begin
                    if (at_end) begin
                        a_next  = '0;
                        st_next = S_CLR;
                    end else begin
                        t_next  = t_reg + 1'b1;
                        st_next = S_RD;
                    end
                end else if (wb_reg >= total) begin
                    a_next  = '0;
                    st_next = S_CLR;
                end else begin
                    wf_next   = total - wb_reg;
                    sumf_next = sum_reg - sumb_reg;
                    div_start = 1'b1;
                    st_next   = S_DIV1;
                end
            end
            S_DIV1: begin
                div_dividend = sumf_reg;
                div_divisor  = wf_reg;
                if (div_done) begin
                    mb_next   = div_q;
                    div_start = 1'b1;
                    st_next   = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    mf_next = div_q;
                    st_next = S_MUL1;
                end
            end
            S_MUL1: begin
                prod_next = {{CW{1'b0}}, wb_reg} * {{CW{1'b0}}, wf_reg};
                d2_next   = {{BW{1'b0}}, diff} * {{BW{1'b0}}, diff};
                st_next   = S_MUL2;
            end
            S_MUL2: begin
                score_next = {{(2*BW){1'b0}}, prod_reg} * {{PW{1'b0}}, d2_reg};
                st_next    = S_CMP;
            end
            S_CMP: begin
                if (score_reg > best_reg) begin
                    best_next = score_reg;
                    thr_next  = t_reg;
                end
                if (at_end) begin
                    a_next  = '0;
                    st_next = S_CLR;
                end else begin
                    t_next  = t_reg + 1'b1;
                    st_next = S_RD;
                end
            end
            // zero the histogram for the next image
            S_CLR: begin
                req.clr_en   = 1'b1;
                req.clr_addr = a_reg[BW-1:0];
                a_next       = a_reg + 1'b1;
                if (a_reg[BW-1:0] == BW'(otb_pkg::NUM_BINS - 1)) begin
                    st_next = S_FIN;
                end
            end
            S_FIN: begin
                done    = 1'b1;
                st_next = S_IDLE;
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    // out of reset the histogram memory gets one clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLR;
            dv_reg <= 1'b0;
            a_reg  <= '0;
        end else begin
            st_reg <= st_next;
            dv_reg <= dv_next;
            a_reg  <= a_next;
        end
        di_reg    <= di_next;
        sum_reg   <= sum_next;
        t_reg     <= t_next;
        wb_reg    <= wb_next;
        wf_reg    <= wf_next;
        sumb_reg  <= sumb_next;
        sumf_reg  <= sumf_next;
        mb_reg    <= mb_next;
        mf_reg    <= mf_next;
        prod_reg  <= prod_next;
        d2_reg    <= d2_next;
        score_reg <= score_next;
        best_reg  <= best_next;
        thr_reg   <= thr_next;
    end

    assign thr = thr_reg;

endmodule

FILE: sv/otsu_threshold_binarizer.sv
// Otsu binarizer for 8-bit grey pixels. Out of reset s_ready stays low while the histogram
// memory is cleared. Accumulate and classify beats are then taken one per cycle while the
// result output is not stalled: each accumulate beat, up to 65536 per image, does a
// read-modify-write of one bin in the 256-entry histogram memory, with the previous write
// forwarded when the same bin follows. The accumulate beat marked last stops intake for
// the threshold search: the intensities are summed, then each scanned bin that splits the
// pixels takes two divisions on the shared divider, two multiply stages and the compare,
// and the histogram is cleared. A report beat then carries the new threshold with
// threshold_done set and a mask of 0; classify beats give 255 above the threshold, else 0.
module otsu_threshold_binarizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  otb_pkg::otb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output otb_pkg::otb_out_t m_data
);

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_DRAIN  = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_REPORT = 3'd3;
    localparam logic [2:0] ST_INIT   = 3'd4;

    logic [2:0]                st_reg, st_next;
    logic [otb_pkg::CNT_W-1:0] count_reg, count_next;
    logic [otb_pkg::BIN_W-1:0] thr_reg, thr_next;
    logic                      m_valid_reg, m_valid_next;
    otb_pkg::otb_out_t         m_data_reg, m_data_next;

    logic                      accept;
    logic                      out_free;
    logic                      can_count;
    logic                      acc_valid;
    logic                      srch_start;
    logic                      srch_done;
    logic [otb_pkg::BIN_W-1:0] srch_thr;
    logic [otb_pkg::CNT_W-1:0] rd_data;
    otb_pkg::hist_req_t        req;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (st_reg == ST_RUN) && out_free;
    assign accept    = s_valid && s_ready;
    assign can_count = count_reg < otb_pkg::CNT_W'(otb_pkg::MAX_PIXELS);
    assign acc_valid = accept && (s_data.kind == otb_pkg::KIND_ACCUM) && can_count;

    otb_hist u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_valid (acc_valid),
        .acc_bin   (s_data.pixel),
        .req       (req),
        .rd_data   (rd_data)
    );

    otb_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (srch_start),
        .total   (count_reg),
        .rd_data (rd_data),
        .req     (req),
        .done    (srch_done),
        .thr     (srch_thr)
    );

    always_comb begin
        st_next      = st_reg;
        count_next   = count_reg;
        thr_next     = thr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        srch_start   = 1'b0;

        unique case (st_reg)
            // wait for the histogram clear after reset
            ST_INIT: begin
                if (srch_done) begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (accept) begin
                    if (s_data.kind == otb_pkg::KIND_CLASSIFY) begin
                        m_valid_next              = 1'b1;
                        m_data_next.mask_value    = (s_data.pixel > thr_reg) ?
                                                    otb_pkg::FG_VALUE : otb_pkg::BG_VALUE;
                        m_data_next.threshold     = thr_reg;
                        m_data_next.threshold_done = 1'b0;
                    end else begin
                        if (can_count) begin
                            count_next = count_reg + 1'b1;
                        end
                        if (s_data.last) begin
                            st_next = ST_DRAIN;
                        end
                    end
                end
            end
            // let the last histogram write land before the search reads
            ST_DRAIN: begin
                srch_start = 1'b1;
                st_next    = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (srch_done) begin
                    thr_next = srch_thr;
                    st_next  = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.mask_value     = otb_pkg::BG_VALUE;
                    m_data_next.threshold      = thr_reg;
                    m_data_next.threshold_done = 1'b1;
                    count_next                 = '0;
                    st_next                    = ST_RUN;
                end
            end
            default: begin
                st_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_INIT;
            count_reg   <= '0;
            thr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            count_reg   <= count_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/otb_checker.sv
`include "otsu_threshold_binarizer_assert.svh"

module otb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input otb_pkg::otb_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input otb_pkg::otb_out_t m_data
);

    `OTB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")
    `OTB_ASSERT_IMPL(a_mask_binary, m_valid, m_data.mask_value == otb_pkg::FG_VALUE || m_data.mask_value == otb_pkg::BG_VALUE, "mask byte not binary")
    `OTB_ASSERT_IMPL(a_report_mask, m_valid && m_data.threshold_done, m_data.mask_value == otb_pkg::BG_VALUE, "threshold report with nonzero mask")
    `OTB_ASSERT_NEXT(a_classify_out, s_valid && s_ready && s_data.kind == otb_pkg::KIND_CLASSIFY, m_valid && !m_data.threshold_done, "classify beat gave no result")

endmodule

bind otsu_threshold_binarizer otb_checker u_otb_checker (.*);
